>>> design/mmcpu_pkg.sv
// shared types and constants for the memory-to-memory three-operand cpu core
// no dependencies

package mmcpu_pkg;

	localparam int MEM_WORDS = 4096;
	localparam int ADDR_W    = $clog2(MEM_WORDS);
	localparam int WORD_W    = 32;
	localparam int COUNT_W   = 64;
	localparam int ACT_W     = 2;

	// request payload: word_address, write_value, padded to bytes
	localparam int IN_BITS   = 12 + WORD_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// response payload: read_value, halted, program_counter, executed_count
	localparam int OUT_BITS   = WORD_W + 1 + WORD_W + COUNT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_STEP  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [WORD_W-1:0] OPC_MOVE = 32'd0;
	localparam logic [WORD_W-1:0] OPC_SUB  = 32'd1;
	localparam logic [WORD_W-1:0] OPC_KEEP = 32'd2;
	localparam logic [WORD_W-1:0] PC_STEP  = 32'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_EX_PC,
		ST_EX_OPC,
		ST_EX_A1,
		ST_EX_A2,
		ST_EX_OP1,
		ST_EX_OP2,
		ST_EX_WB,
		ST_RESP
	} state_t;

endpackage

>>> design/memory_to_memory_three_op_cpu_core.sv
// top level of the memory-to-memory three-operand cpu core
// holds the sequencer, the single-port word memory and the output register
// depends on mmcpu_pkg

// One request is handled at a time. A write, a read and a step that finds the program counter
// at zero each pass through their own working state (ST_WRITE, ST_READ or ST_EX_PC) before
// the response state, an unknown action goes straight to the response state, and an executed
// instruction passes through the states ST_EX_PC to ST_EX_WB. In an executed instruction the
// program counter update, three fetches, two operand reads and the write-back all go one
// after another through the single port of the word memory. The input opens in the same cycle
// that the response turns valid. A finished request is held in the response state while an
// earlier response still waits in the output register, until it drains. The memory has no
// reset; a word must be written before it is read. Word 0 is mirrored in a register that reset
// clears, so program_counter reads zero until word 0 is written. The response sits in an
// output register, so the next request is taken while a response still waits.

module memory_to_memory_three_op_cpu_core
	import mmcpu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // word_address[11:0], write_value[43:12]
	input  logic [ACT_W-1:0]      s_tuser,  // action[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // read_value[31:0], halted[32],
	                                        // program_counter[64:33],
	                                        // executed_count[128:65]
);

	state_t state_q, state_d;

	logic [WORD_W-1:0]  mem [MEM_WORDS];
	logic [WORD_W-1:0]  rdata_q;
	logic               mem_we, mem_re;
	logic [ADDR_W-1:0]  mem_addr;
	logic [WORD_W-1:0]  mem_wdata;

	action_t            act_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [WORD_W-1:0]  wval_q;
	logic [WORD_W-1:0]  pc_q;
	logic [WORD_W-1:0]  base_q;
	logic [WORD_W-1:0]  opc_q, a1_q, a2_q, op1_q;
	logic [COUNT_W-1:0] count_q;
	logic               halt_q;
	logic [WORD_W-1:0]  result;
	logic               accept, load_out;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_RESP) && (!m_tvalid_q || m_tready);

	always_comb begin
		case (opc_q)
			OPC_MOVE: result = rdata_q;
			OPC_SUB:  result = op1_q - rdata_q;
			OPC_KEEP: result = (rdata_q != '0) ? op1_q : '0;
			default:  result = op1_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = addr_q;
		mem_wdata = wval_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action_t'(s_tuser))
						ACT_WRITE: state_d = ST_WRITE;
						ACT_READ:  state_d = ST_READ;
						ACT_STEP:  state_d = ST_EX_PC;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_WRITE: begin
				mem_we  = 1'b1;
				state_d = ST_RESP;
			end
			ST_READ: begin
				mem_re  = 1'b1;
				state_d = ST_RESP;
			end
			ST_EX_PC: begin
				if (pc_q == '0) begin
					state_d = ST_RESP;
				end else begin
					mem_we    = 1'b1;
					mem_addr  = '0;
					mem_wdata = pc_q + PC_STEP;
					state_d   = ST_EX_OPC;
				end
			end
			ST_EX_OPC: begin
				mem_re   = 1'b1;
				mem_addr = base_q[ADDR_W-1:0];
				state_d  = ST_EX_A1;
			end
			ST_EX_A1: begin
				mem_re   = 1'b1;
				mem_addr = base_q[ADDR_W-1:0] + ADDR_W'(1);
				state_d  = ST_EX_A2;
			end
			ST_EX_A2: begin
				mem_re   = 1'b1;
				mem_addr = base_q[ADDR_W-1:0] + ADDR_W'(2);
				state_d  = ST_EX_OP1;
			end
			ST_EX_OP1: begin
				// operand address a1 was captured on the last edge
				mem_re   = 1'b1;
				mem_addr = a1_q[ADDR_W-1:0];
				state_d  = ST_EX_OP2;
			end
			ST_EX_OP2: begin
				mem_re   = 1'b1;
				mem_addr = a2_q[ADDR_W-1:0];
				state_d  = ST_EX_WB;
			end
			ST_EX_WB: begin
				mem_we    = 1'b1;
				mem_addr  = a1_q[ADDR_W-1:0];
				mem_wdata = result;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// request fields and operand captures
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action_t'(s_tuser);
			addr_q <= s_tdata[ADDR_W-1:0];
			wval_q <= s_tdata[12 +: WORD_W];
			base_q <= pc_q;
		end
		case (state_q)
			ST_EX_A1:  opc_q <= rdata_q;
			ST_EX_A2:  a1_q  <= rdata_q;
			ST_EX_OP1: a2_q  <= rdata_q;
			ST_EX_OP2: op1_q <= rdata_q;
			default: ;
		endcase
	end

	// word 0 mirror, instruction count and halt flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			count_q <= '0;
			halt_q  <= 1'b0;
		end else begin
			if (accept) begin
				halt_q <= 1'b0;
			end
			if (mem_we && mem_addr == '0) begin
				pc_q <= mem_wdata;
			end
			if (state_q == ST_EX_PC && pc_q == '0) begin
				halt_q <= 1'b1;
			end
			if (state_q == ST_EX_WB) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {(OUT_DATA_W - OUT_BITS)'(0), count_q, pc_q, halt_q,
				(act_q == ACT_READ) ? rdata_q : {WORD_W{1'b0}}};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> design/mmcpu_checker.sv
// port-level checker for memory_to_memory_three_op_cpu_core, with its bind
// depends on mmcpu_pkg

module mmcpu_checker
	import mmcpu_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// one request at a time: an accepted request closes the input for a while
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted back to back");

	a_halt_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[WORD_W]) |-> (m_tdata[WORD_W-1:0] == '0))
		else $error("halted response carries read data");

	a_halt_pc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[WORD_W]) |-> (m_tdata[WORD_W+1 +: WORD_W] == '0))
		else $error("halted with nonzero program counter");

	a_resp_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled response changed");

endmodule

bind memory_to_memory_three_op_cpu_core mmcpu_checker u_mmcpu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
